FILE: src/mstp_pkg.sv
`default_nettype none

package mstp_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int CMD_W    = 1;
  localparam int VTX_W    = 4;
  localparam int WEIGHT_W = 16;
  localparam int VCOUNT_W = 5;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Control for the best-edge tracker.
  typedef struct packed {
    logic clear;
    logic sample;
  } best_ctl_t;

endpackage

`default_nettype wire

FILE: src/minimum_spanning_tree_prim_unit.sv
// Prim minimum spanning tree over a weight matrix held in a synchronous memory with
// one write port and one read port. A load item writes one matrix entry. A start
// item makes the block busy for the whole search: each round reads all n*n entries
// of the used vertices through the read port, one a cycle, then may wait for the
// output register to be free, and a run has up to n-1 rounds. A start can also end
// at once with a marker. After reset the block clears the memory, one entry a cycle,
// all 256 entries with the default sizes (2 to the power of twice the vertex index
// width in general), and accepts no item until that pass is done.
`default_nettype none

module minimum_spanning_tree_prim_unit
  import mstp_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [VCOUNT_W-1:0] cfg_wdata,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // row [3:0], col [7:4], weight [23:8], start_vertex [27:24], zero [31:28]
  input  wire logic [31:0]         s_axis_tdata,
  // cmd
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // edge_src [3:0], edge_dest [7:4], edge_weight [23:8]
  output logic [23:0]              m_axis_tdata,
  // edge_valid [0], connected [1]
  output logic [1:0]               m_axis_tuser,
  output logic                     m_axis_tlast
);

  localparam int NV = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
  localparam int SW = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int VW = $clog2(NV);
  localparam int NW = $clog2(NV + 1);
  localparam int VD = 1 << VW;
  localparam int AW = 2 * VW;
  localparam int MD = 1 << AW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t              state;
  logic [VCOUNT_W-1:0] vertex_count;
  logic [AW-1:0]       clr_addr;
  logic [VW-1:0]       si;
  logic [VW-1:0]       sj;
  logic                rd_vld;
  logic [VW-1:0]       rd_i;
  logic [VW-1:0]       rd_j;
  logic [VD-1:0]       visited;
  logic [NW-1:0]       cnt;
  logic                mark_conn;

  logic [SW-1:0]       mem [MD];
  logic [SW-1:0]       mem_q;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [SW-1:0]       mem_wd;

  logic                in_cmd;
  logic [VTX_W-1:0]    in_row;
  logic [VTX_W-1:0]    in_col;
  logic [WEIGHT_W-1:0] in_weight;
  logic [VTX_W-1:0]    in_sv;

  logic [NW-1:0]       n_eff;
  logic [NW-1:0]       nm1;
  logic                in_acc;
  logic                out_free;
  logic                last_ij;
  logic                last_edge;
  logic                sv_bad;
  logic                row_ok;

  best_ctl_t           best_ctl;
  logic                best_found;
  logic [VW-1:0]       best_src;
  logic [VW-1:0]       best_dest;
  logic [SW-1:0]       best_w;

  assign in_cmd    = s_axis_tuser;
  assign in_row    = s_axis_tdata[3:0];
  assign in_col    = s_axis_tdata[7:4];
  assign in_weight = s_axis_tdata[23:8];
  assign in_sv     = s_axis_tdata[27:24];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign n_eff     = (vertex_count > VCOUNT_W'(NV)) ? NW'(NV) : vertex_count[NW-1:0];
  assign nm1       = n_eff - NW'(1);
  assign last_ij   = (si == nm1[VW-1:0]) && (sj == nm1[VW-1:0]);
  assign last_edge = (cnt == n_eff - NW'(2));
  assign sv_bad    = ({1'b0, in_sv} >= VCOUNT_W'(n_eff));
  assign row_ok    = ({1'b0, in_row} < VCOUNT_W'(NV)) && ({1'b0, in_col} < VCOUNT_W'(NV));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (in_acc && (in_cmd == CMD_LOAD) && row_ok) begin
      mem_we = 1'b1;
      mem_wa = {in_row[VW-1:0], in_col[VW-1:0]};
      mem_wd = in_weight[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[{si, sj}];
  end

  always_comb begin
    best_ctl.clear  = (in_acc && (in_cmd == CMD_START)) ||
                      ((state == ST_EMIT) && out_free);
    best_ctl.sample = rd_vld && visited[rd_i] && !visited[rd_j];
  end

  mstp_best #(
    .VW(VW),
    .SW(SW)
  ) u_best (
    .clk  (clk),
    .rst  (rst),
    .ctl  (best_ctl),
    .rd_i (rd_i),
    .rd_j (rd_j),
    .rd_w (mem_q),
    .found(best_found),
    .src  (best_src),
    .dest (best_dest),
    .w    (best_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      vertex_count  <= VCOUNT_RESET;
      clr_addr      <= '0;
      si            <= '0;
      sj            <= '0;
      rd_vld        <= 1'b0;
      visited       <= '0;
      cnt           <= '0;
      mark_conn     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
      if ((state == ST_EMIT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      rd_vld <= (state == ST_SCAN);
      rd_i   <= si;
      rd_j   <= sj;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && (in_cmd == CMD_START)) begin
            cnt       <= '0;
            si        <= '0;
            sj        <= '0;
            mark_conn <= 1'b0;
            if (sv_bad) begin
              visited <= '0;
              state   <= ST_EMIT;
            end else begin
              visited <= VD'(1) << in_sv[VW-1:0];
              if (n_eff == NW'(1)) begin
                mark_conn <= 1'b1;
                state     <= ST_EMIT;
              end else begin
                state <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (last_ij) begin
            state <= ST_DRAIN;
          end else if (sj == nm1[VW-1:0]) begin
            sj <= '0;
            si <= si + VW'(1);
          end else begin
            sj <= sj + VW'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            si <= '0;
            sj <= '0;
            if (best_found) begin
              m_axis_tdata       <= {16'(best_w), VTX_W'(best_dest), VTX_W'(best_src)};
              m_axis_tuser       <= 2'b11;
              m_axis_tlast       <= last_edge;
              visited[best_dest] <= 1'b1;
              cnt                <= cnt + NW'(1);
              state              <= last_edge ? ST_IDLE : ST_SCAN;
            end else begin
              m_axis_tdata <= '0;
              m_axis_tuser <= {mark_conn, 1'b0};
              m_axis_tlast <= 1'b1;
              state        <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The visited set grows by exactly one vertex per emitted edge.
  a_visited_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ($countones(visited) == int'(cnt) + 1))
    else $error("visited set does not match the edge count");

  // A chosen edge always leads to a vertex not yet in the tree.
  a_dest_unvisited: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT) && best_found) |-> !visited[best_dest])
    else $error("chosen edge leads to a visited vertex");

  // A round never starts once the tree is complete.
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cnt < nm1))
    else $error("search round started after the tree was complete");

  // The tracker sees data only for reads issued during a scan.
  a_sample_after_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> ($past(state) == ST_SCAN))
    else $error("read data sampled outside a scan");

endmodule

`default_nettype wire

FILE: src/mstp_best.sv
`default_nettype none

module mstp_best
  import mstp_pkg::*;
#(
  parameter int VW = 4,
  parameter int SW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire best_ctl_t     ctl,
  input  wire logic [VW-1:0] rd_i,
  input  wire logic [VW-1:0] rd_j,
  input  wire logic [SW-1:0] rd_w,
  output logic               found,
  output logic [VW-1:0]      src,
  output logic [VW-1:0]      dest,
  output logic [SW-1:0]      w
);

  logic better;

  assign better = ctl.sample && (rd_w != '0) && (!found || (rd_w < w));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (better) begin
      found <= 1'b1;
      src   <= rd_i;
      dest  <= rd_j;
      w     <= rd_w;
    end
  end

endmodule

`default_nettype wire

FILE: sim/minimum_spanning_tree_prim_unit_tb.sv
module minimum_spanning_tree_prim_unit_tb;
  import mstp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic                cmd;
    logic [VTX_W-1:0]    start_vertex;
    logic [WEIGHT_W-1:0] weight;
    logic [VTX_W-1:0]    col;
    logic [VTX_W-1:0]    row;
  } graph_item_t;

  typedef struct packed {
    logic [VTX_W-1:0]    src;
    logic [VTX_W-1:0]    dest;
    logic [WEIGHT_W-1:0] weight;
    logic                edge_valid;
    logic                connected;
    logic                last;
  } tree_edge_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [VCOUNT_W-1:0] cfg_wdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;
  logic                s_axis_tuser = CMD_LOAD;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  graph_item_t         graph_items[$];
  tree_edge_t          expected_edges[$];
  logic [WEIGHT_W-1:0] weight_matrix[MAX_VERTICES_DEF][MAX_VERTICES_DEF];
  logic [VCOUNT_W-1:0] vertex_count = VCOUNT_RESET;
  int                  items_queued = 0;
  int                  items_taken = 0;
  int                  mismatches = 0;
  int                  quiet_cycles = 0;
  int                  idle_pct = 30;
  int                  phase_counts[8] = '{2, 3, 5, 8, 16, 31, 6, 12};

  minimum_spanning_tree_prim_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < MAX_VERTICES_DEF; i++) begin
      for (int j = 0; j < MAX_VERTICES_DEF; j++) begin
        weight_matrix[i][j] = '0;
      end
    end
  end

  function automatic void push_edge(int src, int dest, int weight, bit ev, bit conn, bit last);
    expected_edges.push_back(tree_edge_t'{src: VTX_W'(src), dest: VTX_W'(dest),
                                          weight: WEIGHT_W'(weight), edge_valid: ev,
                                          connected: conn, last: last});
  endfunction

  // Grows the tree one edge per round from the given root.
  function automatic void predict_tree(int root);
    int                  n;
    int                  best_src;
    int                  best_dest;
    logic [WEIGHT_W-1:0] best_weight;
    bit                  found;
    logic [15:0]         in_tree;
    n = (vertex_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(vertex_count);
    if (root >= n) begin
      push_edge(0, 0, 0, 0, 0, 1);
      return;
    end
    in_tree = 16'b1 << root;
    if (n == 1) begin
      push_edge(0, 0, 0, 0, 1, 1);
      return;
    end
    for (int round = 0; round < n - 1; round++) begin
      found = 0;
      best_src = 0;
      best_dest = 0;
      best_weight = '0;
      for (int i = 0; i < n; i++) begin
        if (in_tree[i]) begin
          for (int j = 0; j < n; j++) begin
            if (weight_matrix[i][j] != 0 && !in_tree[j] &&
                (!found || weight_matrix[i][j] < best_weight)) begin
              found = 1;
              best_src = i;
              best_dest = j;
              best_weight = weight_matrix[i][j];
            end
          end
        end
      end
      if (!found) begin
        push_edge(0, 0, 0, 0, 0, 1);
        return;
      end
      in_tree[best_dest] = 1'b1;
      push_edge(best_src, best_dest, best_weight, 1, 1, round == n - 2);
    end
  endfunction

  function automatic void add_load(int row, int col, int weight);
    graph_items.push_back(graph_item_t'{cmd: CMD_LOAD, start_vertex: VTX_W'($urandom_range(15)),
                                        weight: WEIGHT_W'(weight), col: VTX_W'(col),
                                        row: VTX_W'(row)});
    items_queued++;
  endfunction

  function automatic void add_start(int root);
    graph_items.push_back(graph_item_t'{cmd: CMD_START, start_vertex: VTX_W'(root),
                                        weight: WEIGHT_W'($urandom_range(65535)),
                                        col: VTX_W'($urandom_range(15)),
                                        row: VTX_W'($urandom_range(15))});
    items_queued++;
  endfunction

  function automatic int pick_weight(bit allow_zero);
    case ($urandom_range(9))
      0: return allow_zero ? 0 : 1;
      1: return 16'hFFFF;
      2, 3, 4: return $urandom_range(1, 4);
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  function automatic void note_mismatch(string msg);
    if (mismatches < REPORT_LIMIT) begin
      $display("%s", msg);
    end
    mismatches++;
  endfunction

  task automatic wait_drained();
    while (graph_items.size() != 0 || items_taken != items_queued ||
           expected_edges.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(int value);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= VCOUNT_W'(value);
    vertex_count = VCOUNT_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : drive_items
    graph_item_t next_item;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (graph_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_item = graph_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, next_item.start_vertex, next_item.weight, next_item.col,
                         next_item.row};
        s_axis_tuser <= next_item.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin : watch_results
    tree_edge_t got;
    tree_edge_t want;
    bit         progress;
    if (!rst) begin
      progress = 0;
      if (s_axis_tvalid && s_axis_tready) begin
        progress = 1;
        items_taken++;
        if (s_axis_tuser == CMD_LOAD) begin
          weight_matrix[s_axis_tdata[3:0]][s_axis_tdata[7:4]] = s_axis_tdata[23:8];
        end else begin
          predict_tree(s_axis_tdata[27:24]);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        progress = 1;
        got = tree_edge_t'{src: m_axis_tdata[3:0], dest: m_axis_tdata[7:4],
                           weight: m_axis_tdata[23:8], edge_valid: m_axis_tuser[0],
                           connected: m_axis_tuser[1], last: m_axis_tlast};
        if (expected_edges.size() == 0) begin
          note_mismatch($sformatf("mismatch: unexpected edge src=%0d dest=%0d w=%0d v=%b c=%b l=%b",
                                  got.src, got.dest, got.weight, got.edge_valid,
                                  got.connected, got.last));
        end else begin
          want = expected_edges.pop_front();
          if (got !== want) begin
            note_mismatch($sformatf({"mismatch: expected src=%0d dest=%0d w=%0d v=%b c=%b l=%b,",
                                     " got src=%0d dest=%0d w=%0d v=%b c=%b l=%b"},
                                    want.src, want.dest, want.weight, want.edge_valid,
                                    want.connected, want.last, got.src, got.dest, got.weight,
                                    got.edge_valid, got.connected, got.last));
          end
        end
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int chain_loads;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_vertex_count(4);
    add_load(0, 1, 5);
    add_load(0, 2, 16'hFFFF);
    add_load(1, 2, 5);
    add_load(1, 3, 5);
    add_load(2, 3, 1);
    add_load(3, 2, 1);
    add_load(9, 0, 7);
    add_load(0, 3, 0);
    add_start(0);
    add_start(2);
    add_start(4);
    add_start(15);
    add_load(2, 3, 0);
    add_start(0);
    set_vertex_count(1);
    add_start(0);
    add_start(1);
    set_vertex_count(0);
    add_start(0);
    set_vertex_count(31);
    add_start(15);

    for (int p = 0; p < 8; p++) begin
      idle_pct = (p == 4) ? 0 : 30;
      set_vertex_count(phase_counts[p]);
      n = (phase_counts[p] > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : phase_counts[p];
      chain_loads = 0;
      for (int v = 1; v < n; v++) begin
        chain_loads = $urandom_range(v - 1);
        add_load(chain_loads, v, pick_weight(0));
        add_load(v, chain_loads, pick_weight(0));
        if (v == n / 2) begin
          add_start($urandom_range(n - 1));
        end
      end
      for (int k = 0; k < n + n / 2; k++) begin
        if ($urandom_range(7) == 0) begin
          add_load($urandom_range(15), $urandom_range(15), pick_weight(1));
        end else begin
          add_load($urandom_range(n - 1), $urandom_range(n - 1), pick_weight(1));
        end
      end
      for (int k = 0; k < 4; k++) begin
        add_start(($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(n - 1));
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
